/* rtl/core/spmf_pkg.sv */
`default_nettype none

package spmf_pkg;

   // Sizing of the queues.
   localparam int DEPTH       = 32;
   localparam int NUM_CLASSES = 6;
   localparam int HANDLE_BITS = 16;

   // Number of capacity registers in the register map.
   localparam int CAP_REGS = 6;
   localparam int CAP_USED = (NUM_CLASSES < CAP_REGS) ? NUM_CLASSES : CAP_REGS;

   // Field widths fixed by the interface.
   localparam int OP_W    = 2;
   localparam int CLASS_W = 3;
   localparam int TIME_W  = 32;
   localparam int STAT_W  = 2;
   localparam int LEVEL_W = 6;
   localparam int COUNT_W = 32;
   localparam int TOTAL_W = 8;
   localparam int CAP_W   = 6;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = CAP_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATS_ENABLE = CSR_INDEX_W'(CAP_REGS);

   // Internal widths derived from the sizing.
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int PTR_W     = $clog2(DEPTH);
   localparam int CLS_IDX_W = $clog2(NUM_CLASSES);
   localparam int ADDR_W    = $clog2(NUM_CLASSES * DEPTH);
   localparam int SUM_W     = $clog2(NUM_CLASSES * DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE         = 2'd0,
      OP_DEQUEUE_HIGHEST = 2'd1,
      OP_DEQUEUE_CLASS   = 2'd2,
      OP_RESET_STATS     = 2'd3
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_INVALID = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
      logic load_out;
   } dp_cmd_type;

   // Effective capacity of a class: zero selects half the depth, and
   // anything above the depth is clipped to it.
   function automatic logic [CNT_W-1:0] class_capacity(input logic [CAP_W-1:0] raw);
      logic [CNT_W-1:0] cap;
      if (raw == '0) begin
         cap = CNT_W'(DEPTH / 2);
      end else if (int'(raw) > DEPTH) begin
         cap = CNT_W'(DEPTH);
      end else begin
         cap = CNT_W'(raw);
      end
      return cap;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/spmf_ctrl.sv */
`default_nettype none

module spmf_ctrl import spmf_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output dp_cmd_type      cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   // State and output-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Next state and commands. A request is taken in idle, the queues are
   // updated in the access cycle, and the result register is loaded in
   // finish as soon as it is free or being emptied.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      out_valid_in = out_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            cmd.execute = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (!out_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

/* rtl/core/spmf_datapath.sv */
`default_nettype none

module spmf_datapath import spmf_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire dp_cmd_type               cmd,
   input  wire logic                     csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_write_data,
   input  wire logic [OP_W-1:0]          req_opcode,
   input  wire logic [CLASS_W-1:0]       req_queue_class,
   input  wire logic [HANDLE_BITS-1:0]   req_handle,
   input  wire logic [TIME_W-1:0]        req_now_ms,
   output logic [STAT_W-1:0]             rsp_status,
   output logic [HANDLE_BITS-1:0]        rsp_out_handle,
   output logic [CLASS_W-1:0]            rsp_served_class,
   output logic [LEVEL_W-1:0]            rsp_class_depth,
   output logic [LEVEL_W-1:0]            rsp_class_peak,
   output logic [COUNT_W-1:0]            rsp_class_enqueued,
   output logic [COUNT_W-1:0]            rsp_class_dequeued,
   output logic [TIME_W-1:0]             rsp_class_last_ms,
   output logic [TOTAL_W-1:0]            rsp_total_pending,
   output logic                          rsp_class_full
);

   // Pointer step with wrap by compare against the capacity.
   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] cap);
      logic [PTR_W:0] nxt;
      nxt = {1'b0, ptr} + 1'b1;
      if (int'(nxt) >= int'(cap)) begin
         return '0;
      end
      return PTR_W'(nxt);
   endfunction

   // Captured request.
   opcode_type              op_ff;
   logic [CLASS_W-1:0]      class_ff;
   logic [HANDLE_BITS-1:0]  handle_ff;
   logic [TIME_W-1:0]       now_ff;

   // Configuration.
   logic [CAP_W-1:0]        cap_ff [CAP_REGS];
   logic                    stats_en_ff;

   // Per-class queue state and statistics.
   logic [PTR_W-1:0]        head_ff [NUM_CLASSES];
   logic [PTR_W-1:0]        tail_ff [NUM_CLASSES];
   logic [CNT_W-1:0]        fill_ff [NUM_CLASSES];
   logic [CNT_W-1:0]        peak_ff [NUM_CLASSES];
   logic [COUNT_W-1:0]      enq_ff  [NUM_CLASSES];
   logic [COUNT_W-1:0]      deq_ff  [NUM_CLASSES];
   logic [TIME_W-1:0]       last_ff [NUM_CLASSES];
   logic [SUM_W-1:0]        total_ff;

   // Handle store and its registered read data.
   logic [HANDLE_BITS-1:0]  store_mem [NUM_CLASSES * DEPTH];
   logic [HANDLE_BITS-1:0]  rd_data_ff;

   // Staged result of the access cycle.
   status_type              st_status_ff, st_status_in;
   logic [CLASS_W-1:0]      st_class_ff, st_class_in;
   logic                    st_took_ff;
   logic [CNT_W-1:0]        st_depth_ff, st_depth_in;
   logic [CNT_W-1:0]        st_peak_ff, st_peak_in;
   logic [COUNT_W-1:0]      st_enq_ff, st_enq_in;
   logic [COUNT_W-1:0]      st_deq_ff, st_deq_in;
   logic [TIME_W-1:0]       st_last_ff, st_last_in;
   logic                    st_full_ff, st_full_in;

   // Access-cycle decode.
   logic [CNT_W-1:0]        class_cap [NUM_CLASSES];
   logic                    class_valid;
   logic                    any_busy;
   logic [CLS_IDX_W-1:0]    hi_idx;
   logic [CLS_IDX_W-1:0]    target_idx;
   logic [CNT_W-1:0]        t_cap, t_fill, t_peak;
   logic [PTR_W-1:0]        t_head, t_tail;
   logic [COUNT_W-1:0]      t_enq, t_deq;
   logic [TIME_W-1:0]       t_last;
   logic                    do_enq, do_deq, show;
   logic [PTR_W-1:0]        head_in, tail_in, mem_ptr;
   logic [CNT_W-1:0]        fill_in, peak_in;
   logic [COUNT_W-1:0]      enq_in, deq_in;
   logic [TIME_W-1:0]       last_in;
   logic [ADDR_W-1:0]       mem_addr;

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= opcode_type'(req_opcode);
         class_ff  <= req_queue_class;
         handle_ff <= req_handle;
         now_ff    <= req_now_ms;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAP_REGS; i++) begin
            cap_ff[i] <= '0;
         end
         stats_en_ff <= 1'b1;
      end else if (csr_write_enable) begin
         for (int i = 0; i < CAP_REGS; i++) begin
            if (csr_index == CSR_INDEX_W'(i)) begin
               cap_ff[i] <= CAP_W'(csr_write_data);
            end
         end
         if (csr_index == CSR_STATS_ENABLE) begin
            stats_en_ff <= csr_write_data[0];
         end
      end
   end

   // Effective capacity of each class.
   always_comb begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
         class_cap[i] = class_capacity('0);
      end
      for (int i = 0; i < CAP_USED; i++) begin
         class_cap[i] = class_capacity(cap_ff[i]);
      end
   end

   // Priority encoder over the non-empty flags, class 0 wins.
   always_comb begin
      any_busy = 1'b0;
      hi_idx   = '0;
      for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
         if (fill_ff[i] != '0) begin
            any_busy = 1'b1;
            hi_idx   = CLS_IDX_W'(i);
         end
      end
   end

   // Class selection and read of its state.
   assign class_valid = {1'b0, class_ff} < (CLASS_W + 1)'(NUM_CLASSES);

   always_comb begin
      if (op_ff == OP_DEQUEUE_HIGHEST) begin
         target_idx = any_busy ? hi_idx : '0;
      end else begin
         target_idx = class_valid ? class_ff[CLS_IDX_W-1:0] : '0;
      end
   end

   assign t_cap  = class_cap[target_idx];
   assign t_fill = fill_ff[target_idx];
   assign t_peak = peak_ff[target_idx];
   assign t_head = head_ff[target_idx];
   assign t_tail = tail_ff[target_idx];
   assign t_enq  = enq_ff[target_idx];
   assign t_deq  = deq_ff[target_idx];
   assign t_last = last_ff[target_idx];

   // Operation decode and the new state of the selected class.
   always_comb begin
      do_enq = (op_ff == OP_ENQUEUE) && class_valid && (t_fill < t_cap);
      do_deq = ((op_ff == OP_DEQUEUE_HIGHEST) && any_busy) ||
               ((op_ff == OP_DEQUEUE_CLASS) && class_valid && (t_fill != '0));
      show   = !(((op_ff == OP_ENQUEUE) || (op_ff == OP_DEQUEUE_CLASS)) && !class_valid);

      case (op_ff)
         OP_ENQUEUE: begin
            st_status_in = !class_valid ? STATUS_INVALID :
                           (!do_enq ? STATUS_FULL : STATUS_OK);
         end
         OP_DEQUEUE_HIGHEST: begin
            st_status_in = any_busy ? STATUS_OK : STATUS_EMPTY;
         end
         OP_DEQUEUE_CLASS: begin
            st_status_in = !class_valid ? STATUS_INVALID :
                           (!do_deq ? STATUS_EMPTY : STATUS_OK);
         end
         default: begin
            st_status_in = STATUS_OK;
         end
      endcase

      if ((op_ff == OP_DEQUEUE_HIGHEST) || ((op_ff == OP_RESET_STATS) && !class_valid)) begin
         st_class_in = CLASS_W'(target_idx);
      end else begin
         st_class_in = class_ff;
      end

      fill_in = t_fill;
      if (do_enq) begin
         fill_in = t_fill + 1'b1;
      end else if (do_deq) begin
         fill_in = t_fill - 1'b1;
      end
      tail_in = do_enq ? advance(t_tail, t_cap) : t_tail;
      head_in = do_deq ? advance(t_head, t_cap) : t_head;
      last_in = (stats_en_ff && (do_enq || do_deq)) ? now_ff : t_last;

      if (op_ff == OP_RESET_STATS) begin
         enq_in  = '0;
         deq_in  = '0;
         peak_in = t_fill;
      end else begin
         enq_in  = (stats_en_ff && do_enq) ? t_enq + 1'b1 : t_enq;
         deq_in  = (stats_en_ff && do_deq) ? t_deq + 1'b1 : t_deq;
         peak_in = (stats_en_ff && do_enq && (fill_in > t_peak)) ? fill_in : t_peak;
      end

      st_depth_in = show ? fill_in : '0;
      st_peak_in  = show ? peak_in : '0;
      st_enq_in   = show ? enq_in : '0;
      st_deq_in   = show ? deq_in : '0;
      st_last_in  = show ? last_in : '0;
      st_full_in  = show && (fill_in >= t_cap);
   end

   // Per-class state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
            peak_ff[i] <= '0;
            enq_ff[i]  <= '0;
            deq_ff[i]  <= '0;
            last_ff[i] <= '0;
         end
         total_ff <= '0;
      end else if (cmd.execute) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            if (op_ff == OP_RESET_STATS) begin
               enq_ff[i]  <= '0;
               deq_ff[i]  <= '0;
               peak_ff[i] <= fill_ff[i];
            end else if (target_idx == CLS_IDX_W'(i)) begin
               head_ff[i] <= head_in;
               tail_ff[i] <= tail_in;
               fill_ff[i] <= fill_in;
               peak_ff[i] <= peak_in;
               enq_ff[i]  <= enq_in;
               deq_ff[i]  <= deq_in;
               last_ff[i] <= last_in;
            end
         end
         if (do_enq) begin
            total_ff <= total_ff + 1'b1;
         end else if (do_deq) begin
            total_ff <= total_ff - 1'b1;
         end
      end
   end

   // Handle store: each class owns a region of DEPTH slots.
   assign mem_ptr  = do_enq ? t_tail : t_head;
   assign mem_addr = ADDR_W'(int'(target_idx) * DEPTH + int'(mem_ptr));

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         if (do_enq) begin
            store_mem[mem_addr] <= handle_ff;
         end
         rd_data_ff <= store_mem[mem_addr];
      end
   end

   // Staging of the result fields.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         st_status_ff <= st_status_in;
         st_class_ff  <= st_class_in;
         st_took_ff   <= do_deq;
         st_depth_ff  <= st_depth_in;
         st_peak_ff   <= st_peak_in;
         st_enq_ff    <= st_enq_in;
         st_deq_ff    <= st_deq_in;
         st_last_ff   <= st_last_in;
         st_full_ff   <= st_full_in;
      end
   end

   // Output register; it changes only when the controller loads it.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_status         <= st_status_ff;
         rsp_out_handle     <= st_took_ff ? rd_data_ff : '0;
         rsp_served_class   <= st_class_ff;
         rsp_class_depth    <= LEVEL_W'(st_depth_ff);
         rsp_class_peak     <= LEVEL_W'(st_peak_ff);
         rsp_class_enqueued <= st_enq_ff;
         rsp_class_dequeued <= st_deq_ff;
         rsp_class_last_ms  <= st_last_ff;
         rsp_total_pending  <= TOTAL_W'(total_ff);
         rsp_class_full     <= st_full_ff;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/strict_priority_multi_fifo.sv */
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  opcode, queue_class, handle, now_ms
// rsp_      out        rsp_valid/rsp_stall  status, handle, class statistics
// csr_      in         csr_write_enable     csr_index, csr_write_data
//
// A request is accepted, the selected queue is updated and the handle store
// accessed, then the result register is loaded; the registered read port of
// the handle store makes the load a step of its own. A new request is
// accepted in the cycle after the result is loaded, also while it still waits.
// A stalled result holds the finish step until the result register is free.
// Reset is synchronous; all queues are empty and statistics zero afterwards.
`default_nettype none

module strict_priority_multi_fifo import spmf_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [OP_W-1:0]          req_opcode,
   input  wire logic [CLASS_W-1:0]       req_queue_class,
   input  wire logic [HANDLE_BITS-1:0]   req_handle,
   input  wire logic [TIME_W-1:0]        req_now_ms,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [STAT_W-1:0]             rsp_status,
   output logic [HANDLE_BITS-1:0]        rsp_out_handle,
   output logic [CLASS_W-1:0]            rsp_served_class,
   output logic [LEVEL_W-1:0]            rsp_class_depth,
   output logic [LEVEL_W-1:0]            rsp_class_peak,
   output logic [COUNT_W-1:0]            rsp_class_enqueued,
   output logic [COUNT_W-1:0]            rsp_class_dequeued,
   output logic [TIME_W-1:0]             rsp_class_last_ms,
   output logic [TOTAL_W-1:0]            rsp_total_pending,
   output logic                          rsp_class_full,
   input  wire logic                     csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_write_data
);

   dp_cmd_type cmd;

   // Sequencing of each request.
   spmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Queues, statistics and result register.
   spmf_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_opcode         (req_opcode),
      .req_queue_class    (req_queue_class),
      .req_handle         (req_handle),
      .req_now_ms         (req_now_ms),
      .rsp_status         (rsp_status),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_served_class   (rsp_served_class),
      .rsp_class_depth    (rsp_class_depth),
      .rsp_class_peak     (rsp_class_peak),
      .rsp_class_enqueued (rsp_class_enqueued),
      .rsp_class_dequeued (rsp_class_dequeued),
      .rsp_class_last_ms  (rsp_class_last_ms),
      .rsp_total_pending  (rsp_total_pending),
      .rsp_class_full     (rsp_class_full)
   );

endmodule

`default_nettype wire

/* rtl/core/spmf_checker.sv */
`default_nettype none

module spmf_checker import spmf_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic [STAT_W-1:0]        rsp_status,
   input wire logic [HANDLE_BITS-1:0]   rsp_out_handle,
   input wire logic [LEVEL_W-1:0]       rsp_class_depth,
   input wire logic [COUNT_W-1:0]       rsp_class_enqueued,
   input wire logic                     rsp_class_full
);

   // No result is shown after a reset edge.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result withdrawn");

   // One request at a time: the input stalls right after an accept.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request accepted while one is in progress");

   // Only a successful request can carry a handle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_out_handle == '0)
      else $error("handle returned on a failed request");

   // An invalid class reports no statistics.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_INVALID) |->
         (rsp_class_depth == '0) && (rsp_class_enqueued == '0) && !rsp_class_full)
      else $error("statistics shown for an invalid class");

endmodule

bind strict_priority_multi_fifo spmf_checker u_checker (.*);

`default_nettype wire
